### sv/sgpv_pkg.sv
// ----------------------------------------------------------------------------
// sgpv_pkg
// Shared types and codes for the step gate plan validator: request and
// response payloads, controller/datapath command and status, state codes.
// ----------------------------------------------------------------------------
package sgpv_pkg;

   localparam int MaskW  = 16;
   localparam int CountW = 5;
   localparam int OrdW   = 5;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_OVERLAP = 3'd1;
   localparam logic [2:0] STATUS_ORPHAN  = 3'd2;
   localparam logic [2:0] STATUS_TOPO    = 3'd3;
   localparam logic [2:0] STATUS_EMPTY   = 3'd4;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_INCOMING = 2'd1;
   localparam logic [1:0] KIND_LOCAL    = 2'd2;

   localparam logic [OrdW-1:0] ORD_NONE     = 5'd31;
   localparam logic [OrdW-1:0] ORD_INCOMING = 5'd30;

   typedef struct packed {
      logic [MaskW-1:0] source_onsets;
      logic [MaskW-1:0] retrigger_onsets;
      logic [MaskW-1:0] continuation_steps;
      logic [MaskW-1:0] release_steps;
      logic             source_at_start;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [3:0]        step_index;
      logic [1:0]        ordinal_kind;
      logic [3:0]        source_index;
      logic [MaskW-1:0]  audible_mask;
      logic [CountW-1:0] source_count;
      logic [CountW-1:0] audible_count;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic scan_done;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic step_last;
   } ctrl_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

### sv/sgpv_ctrl.sv
// ----------------------------------------------------------------------------
// sgpv_ctrl
// Sequencer: accepts a request, runs the check scan over all steps, then
// the emitting pass of one response per step.
// ----------------------------------------------------------------------------
module sgpv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output sgpv_pkg::ctrl_cmd_type cmd,
   input  sgpv_pkg::ctrl_stat_type stat
);

   sgpv_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgpv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      busy          = 1'b1;
      unique case (state_ff)
         sgpv_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = sgpv_pkg::ST_SCAN;
            end
         end
         sgpv_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.step_last) begin
               cmd.scan_done = 1'b1;
               state_in      = sgpv_pkg::ST_EMIT;
            end
         end
         sgpv_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            if (stat.step_last) begin
               state_in = sgpv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sgpv_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### sv/sgpv_dpath.sv
// ----------------------------------------------------------------------------
// sgpv_dpath
// Datapath: held masks, shifting step windows, check flags, onset counts
// and source ordinal tracking.
// ----------------------------------------------------------------------------
module sgpv_dpath #(
   parameter int STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sgpv_pkg::req_type       req_data,
   input  sgpv_pkg::ctrl_cmd_type  cmd,
   output sgpv_pkg::ctrl_stat_type stat,
   output logic                    rsp_valid,
   output sgpv_pkg::rsp_type       rsp_data
);

   localparam int StepW = $clog2(STEPS);
   localparam logic [StepW-1:0] StepLast = StepW'(STEPS - 1);

   logic [sgpv_pkg::MaskW-1:0]  src_ff, ret_ff;
   logic [sgpv_pkg::MaskW-1:0]  w_src_ff, w_ret_ff, w_con_ff, w_rel_ff;
   logic [sgpv_pkg::MaskW-1:0]  w_src_in, w_ret_in, w_con_in, w_rel_in;
   logic                        start_flag_ff;
   logic [StepW-1:0]            step_ff, step_in;
   logic                        overlap_ff, empty_ff, orphan_ff, topo_ff;
   logic                        orphan_in, topo_in;
   logic                        seen_ff, seen_in, gate_ff, gate_in;
   logic [sgpv_pkg::CountW-1:0] src_cnt_ff, aud_cnt_ff, src_cnt_in, aud_cnt_in;
   logic [sgpv_pkg::OrdW-1:0]   cur_ord_ff, cur_ord_in, next_ord_ff, next_ord_in;

   logic                        b_src, b_ret, b_con, b_rel, b_aud, seen_now;
   logic [2:0]                  status;
   logic                        ok;
   logic [sgpv_pkg::OrdW-1:0]   ord;

   assign b_src    = w_src_ff[0];
   assign b_ret    = w_ret_ff[0];
   assign b_con    = w_con_ff[0];
   assign b_rel    = w_rel_ff[0];
   assign b_aud    = b_src | b_ret;
   assign seen_now = seen_ff | b_src;

   assign stat.step_last = (step_ff == StepLast);

   always_comb begin
      if (overlap_ff)     status = sgpv_pkg::STATUS_OVERLAP;
      else if (orphan_ff) status = sgpv_pkg::STATUS_ORPHAN;
      else if (topo_ff)   status = sgpv_pkg::STATUS_TOPO;
      else if (empty_ff)  status = sgpv_pkg::STATUS_EMPTY;
      else                status = sgpv_pkg::STATUS_OK;
   end

   assign ok = (status == sgpv_pkg::STATUS_OK);

   always_comb begin
      w_src_in    = w_src_ff;
      w_ret_in    = w_ret_ff;
      w_con_in    = w_con_ff;
      w_rel_in    = w_rel_ff;
      step_in     = step_ff;
      orphan_in   = orphan_ff;
      topo_in     = topo_ff;
      seen_in     = seen_ff;
      gate_in     = gate_ff;
      src_cnt_in  = src_cnt_ff;
      aud_cnt_in  = aud_cnt_ff;
      cur_ord_in  = cur_ord_ff;
      next_ord_in = next_ord_ff;
      ord         = sgpv_pkg::ORD_NONE;

      if (cmd.load) begin
         w_src_in   = req_data.source_onsets;
         w_ret_in   = req_data.retrigger_onsets;
         w_con_in   = req_data.continuation_steps;
         w_rel_in   = req_data.release_steps;
         step_in    = '0;
         orphan_in  = 1'b0;
         topo_in    = 1'b0;
         seen_in    = req_data.source_at_start;
         gate_in    = 1'b0;
         src_cnt_in = sgpv_pkg::CountW'($countones(req_data.source_onsets));
         aud_cnt_in = sgpv_pkg::CountW'($countones(req_data.source_onsets
                                                   | req_data.retrigger_onsets));
      end

      if (cmd.scan) begin
         w_src_in = w_src_ff >> 1;
         w_ret_in = w_ret_ff >> 1;
         w_con_in = w_con_ff >> 1;
         w_rel_in = w_rel_ff >> 1;
         step_in  = step_ff + 1'b1;
         seen_in  = seen_now;
         if (b_ret && !seen_now) begin
            orphan_in = 1'b1;
         end
         if (b_aud) begin
            gate_in = 1'b1;
         end else if (b_con) begin
            if (!gate_ff) topo_in = 1'b1;
         end else if (b_rel) begin
            if (!gate_ff) topo_in = 1'b1;
            gate_in = 1'b0;
         end else begin
            gate_in = 1'b0;
         end
      end

      if (cmd.scan_done) begin
         w_src_in    = src_ff;
         w_ret_in    = ret_ff;
         step_in     = '0;
         cur_ord_in  = start_flag_ff ? sgpv_pkg::ORD_INCOMING : sgpv_pkg::ORD_NONE;
         next_ord_in = '0;
      end

      if (cmd.emit) begin
         w_src_in = w_src_ff >> 1;
         w_ret_in = w_ret_ff >> 1;
         step_in  = step_ff + 1'b1;
         if (b_src) begin
            ord         = next_ord_ff;
            cur_ord_in  = next_ord_ff;
            next_ord_in = next_ord_ff + 1'b1;
         end else if (b_ret) begin
            ord = cur_ord_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= '0;
         start_flag_ff <= 1'b0;
         overlap_ff    <= 1'b0;
         empty_ff      <= 1'b0;
         orphan_ff     <= 1'b0;
         topo_ff       <= 1'b0;
         seen_ff       <= 1'b0;
         gate_ff       <= 1'b0;
         src_cnt_ff    <= '0;
         aud_cnt_ff    <= '0;
         cur_ord_ff    <= sgpv_pkg::ORD_NONE;
         next_ord_ff   <= '0;
      end else begin
         step_ff     <= step_in;
         orphan_ff   <= orphan_in;
         topo_ff     <= topo_in;
         seen_ff     <= seen_in;
         gate_ff     <= gate_in;
         src_cnt_ff  <= src_cnt_in;
         aud_cnt_ff  <= aud_cnt_in;
         cur_ord_ff  <= cur_ord_in;
         next_ord_ff <= next_ord_in;
         if (cmd.load) begin
            start_flag_ff <= req_data.source_at_start;
            overlap_ff    <= |((req_data.source_onsets & req_data.retrigger_onsets)
                               | (req_data.source_onsets & req_data.continuation_steps)
                               | (req_data.source_onsets & req_data.release_steps)
                               | (req_data.retrigger_onsets & req_data.continuation_steps)
                               | (req_data.retrigger_onsets & req_data.release_steps)
                               | (req_data.continuation_steps & req_data.release_steps));
            empty_ff      <= ~|(req_data.source_onsets | req_data.retrigger_onsets
                               | req_data.continuation_steps | req_data.release_steps);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_src_ff <= '0;
         w_ret_ff <= '0;
         w_con_ff <= '0;
         w_rel_ff <= '0;
         src_ff   <= '0;
         ret_ff   <= '0;
      end else begin
         w_src_ff <= w_src_in;
         w_ret_ff <= w_ret_in;
         w_con_ff <= w_con_in;
         w_rel_ff <= w_rel_in;
         if (cmd.load) begin
            src_ff <= req_data.source_onsets;
            ret_ff <= req_data.retrigger_onsets;
         end
      end
   end

   always_comb begin
      rsp_data            = '0;
      rsp_data.status     = status;
      rsp_data.step_index = 4'(step_ff);
      rsp_data.last       = cmd.emit & stat.step_last;
      if (ok) begin
         rsp_data.audible_mask  = src_ff | ret_ff;
         rsp_data.source_count  = src_cnt_ff;
         rsp_data.audible_count = aud_cnt_ff;
         if (ord == sgpv_pkg::ORD_INCOMING) begin
            rsp_data.ordinal_kind = sgpv_pkg::KIND_INCOMING;
         end else if (ord != sgpv_pkg::ORD_NONE) begin
            rsp_data.ordinal_kind = sgpv_pkg::KIND_LOCAL;
            rsp_data.source_index = ord[3:0];
         end
      end
   end

   assign rsp_valid = cmd.emit;

endmodule

### sv/step_gate_plan_validator.sv
// ----------------------------------------------------------------------------
// step_gate_plan_validator
// Checks one bar request (overlap, orphan retrigger, gate topology, empty)
// and plans its steps, giving one response per step.
// ----------------------------------------------------------------------------
//  channel    ports                      handshake
//  request    start, busy, req_data      taken when start & !busy
//  response   rsp_valid, rsp_data        one-cycle strobe, never stalled
//
//  A request runs an accept step, then a check scan of one step per cycle,
//  then the emitting pass of one response per cycle.
//  The step counter in the datapath sets both passes.
//  Synchronous active-high reset returns the sequencer to idle.
//  Responses cannot be held off; busy stays high until the last is out.
// ----------------------------------------------------------------------------
module step_gate_plan_validator #(
   parameter int STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sgpv_pkg::req_type  req_data,
   output logic               rsp_valid,
   output sgpv_pkg::rsp_type  rsp_data
);

   sgpv_pkg::ctrl_cmd_type  cmd;
   sgpv_pkg::ctrl_stat_type stat;

   sgpv_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   sgpv_dpath #(
      .STEPS (STEPS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_rsp_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response outside a busy period");

   a_last_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_data.last |-> rsp_valid)
      else $error("last flag without response");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accept did not start the scan");

   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !busy)
      else $error("still busy after last response");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != sgpv_pkg::STATUS_OK)
         |-> (rsp_data.audible_mask == '0 && rsp_data.source_count == '0
              && rsp_data.ordinal_kind == sgpv_pkg::KIND_NONE))
      else $error("failed request with non-zero plan");

endmodule

### dv/step_gate_plan_validator_tb.sv
// ----------------------------------------------------------------------------
// step_gate_plan_validator_tb
// Self-checking bench for the bar plan validator. A directed table covers
// empty bars, each mask overlap, orphan retriggers, broken gate topology
// and full-bar extremes. Random bars follow, mostly well-formed plans with
// some corrupted and noisy ones. Every step response is checked against
// a plan predicted for each accepted request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module step_gate_plan_validator_tb;

   localparam int STEPS      = 16;
   localparam int DIRECTED_N = 24;
   localparam int RANDOM_N   = 86;

   localparam logic [2:0] S_OK      = sgpv_pkg::STATUS_OK;
   localparam logic [2:0] S_OVERLAP = sgpv_pkg::STATUS_OVERLAP;
   localparam logic [2:0] S_ORPHAN  = sgpv_pkg::STATUS_ORPHAN;
   localparam logic [2:0] S_TOPO    = sgpv_pkg::STATUS_TOPO;
   localparam logic [2:0] S_EMPTY   = sgpv_pkg::STATUS_EMPTY;

   typedef struct packed {
      sgpv_pkg::req_type req;
      logic              typed;
      logic [2:0]        status;
   } bar_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   sgpv_pkg::req_type req_data = '0;
   logic              rsp_valid;
   sgpv_pkg::rsp_type rsp_data;

   sgpv_pkg::rsp_type planned_steps [$];
   bar_row_type       directed_rows [DIRECTED_N];
   int                mismatch_count = 0;
   int                responses_checked = 0;
   int                bars_sent = 0;
   int                status_hits [5];
   logic              gaps_enabled = 1'b1;

   step_gate_plan_validator #(.STEPS(STEPS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void plan_bar(sgpv_pkg::req_type r);
      logic [15:0]       m [4];
      logic [15:0]       aud;
      logic [2:0]        st;
      logic              seen;
      logic              gate;
      logic [4:0]        cur;
      logic [4:0]        nxt;
      logic [4:0]        ord;
      sgpv_pkg::rsp_type e;
      m[0] = r.source_onsets;
      m[1] = r.retrigger_onsets;
      m[2] = r.continuation_steps;
      m[3] = r.release_steps;
      st = sgpv_pkg::STATUS_OK;
      for (int a = 0; a < 4; a++)
         for (int b = a + 1; b < 4; b++)
            if (st == sgpv_pkg::STATUS_OK && (m[a] & m[b]) != '0)
               st = sgpv_pkg::STATUS_OVERLAP;
      if (st == sgpv_pkg::STATUS_OK) begin
         seen = r.source_at_start;
         for (int s = 0; s < STEPS; s++) begin
            if (m[0][s]) seen = 1'b1;
            if (st == sgpv_pkg::STATUS_OK && m[1][s] && !seen)
               st = sgpv_pkg::STATUS_ORPHAN;
         end
      end
      aud = m[0] | m[1];
      if (st == sgpv_pkg::STATUS_OK) begin
         gate = 1'b0;
         for (int s = 0; s < STEPS; s++) begin
            if (st == sgpv_pkg::STATUS_OK) begin
               if (aud[s]) begin
                  gate = 1'b1;
               end else if (m[2][s]) begin
                  if (!gate) st = sgpv_pkg::STATUS_TOPO;
               end else if (m[3][s]) begin
                  if (!gate) st = sgpv_pkg::STATUS_TOPO;
                  gate = 1'b0;
               end else begin
                  gate = 1'b0;
               end
            end
         end
      end
      if (st == sgpv_pkg::STATUS_OK && (aud | m[2] | m[3]) == '0)
         st = sgpv_pkg::STATUS_EMPTY;
      cur = r.source_at_start ? sgpv_pkg::ORD_INCOMING : sgpv_pkg::ORD_NONE;
      nxt = '0;
      for (int s = 0; s < STEPS; s++) begin
         e = '0;
         e.status     = st;
         e.step_index = 4'(s);
         e.last       = (s == STEPS - 1);
         if (st == sgpv_pkg::STATUS_OK) begin
            ord = sgpv_pkg::ORD_NONE;
            if (m[0][s]) begin
               cur = nxt;
               nxt = nxt + 5'd1;
               ord = cur;
            end else if (m[1][s]) begin
               ord = cur;
            end
            if (ord == sgpv_pkg::ORD_INCOMING) begin
               e.ordinal_kind = sgpv_pkg::KIND_INCOMING;
            end else if (ord != sgpv_pkg::ORD_NONE) begin
               e.ordinal_kind = sgpv_pkg::KIND_LOCAL;
               e.source_index = ord[3:0];
            end
            e.audible_mask  = aud;
            e.source_count  = 5'($countones(m[0]));
            e.audible_count = 5'($countones(aud));
         end
         planned_steps.push_back(e);
      end
   endfunction

   // Walks the bar keeping the gate legal, so the plan passes the overlap, orphan and topology checks.
   function automatic sgpv_pkg::req_type make_bar();
      sgpv_pkg::req_type r;
      logic              gate;
      logic              seen;
      int                pick;
      r = '0;
      r.source_at_start = 1'($urandom_range(1));
      gate = 1'b0;
      seen = r.source_at_start;
      for (int s = 0; s < STEPS; s++) begin
         pick = $urandom_range(9);
         if (gate) begin
            if (pick <= 2) begin
               r.continuation_steps[s] = 1'b1;
            end else if (pick <= 4) begin
               r.release_steps[s] = 1'b1;
               gate = 1'b0;
            end else if (pick <= 6 || (pick == 7 && !seen)) begin
               r.source_onsets[s] = 1'b1;
               seen = 1'b1;
            end else if (pick == 7) begin
               r.retrigger_onsets[s] = 1'b1;
            end else begin
               gate = 1'b0;
            end
         end else begin
            if (pick <= 3) begin
               r.source_onsets[s] = 1'b1;
               seen = 1'b1;
               gate = 1'b1;
            end else if (pick == 4 && seen) begin
               r.retrigger_onsets[s] = 1'b1;
               gate = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic send_bar(input sgpv_pkg::req_type r, input logic typed,
                           input logic [2:0] st);
      sgpv_pkg::rsp_type e;
      if (gaps_enabled && $urandom_range(99) < 24) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      bars_sent++;
      if (typed) begin
         for (int s = 0; s < STEPS; s++) begin
            e = '0;
            e.status     = st;
            e.step_index = 4'(s);
            e.last       = (s == STEPS - 1);
            planned_steps.push_back(e);
         end
      end else begin
         plan_bar(r);
      end
   endtask

   // Responses cannot be stalled: each strobe is taken at the edge ending it.
   always @(posedge clock) begin
      sgpv_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (planned_steps.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response %p", $time, rsp_data);
         end else begin
            e = planned_steps.pop_front();
            responses_checked++;
            if (rsp_data !== e) mismatch_count++;
            if (rsp_data.status !== e.status)
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_data.status);
            if (rsp_data.step_index !== e.step_index)
               $display("%0t: step_index exp %0d got %0d", $time, e.step_index,
                        rsp_data.step_index);
            if (rsp_data.ordinal_kind !== e.ordinal_kind)
               $display("%0t: ordinal_kind exp %0d got %0d (step %0d)", $time,
                        e.ordinal_kind, rsp_data.ordinal_kind, e.step_index);
            if (rsp_data.source_index !== e.source_index)
               $display("%0t: source_index exp %0d got %0d (step %0d)", $time,
                        e.source_index, rsp_data.source_index, e.step_index);
            if (rsp_data.audible_mask !== e.audible_mask)
               $display("%0t: audible_mask exp %h got %h", $time, e.audible_mask,
                        rsp_data.audible_mask);
            if (rsp_data.source_count !== e.source_count)
               $display("%0t: source_count exp %0d got %0d", $time, e.source_count,
                        rsp_data.source_count);
            if (rsp_data.audible_count !== e.audible_count)
               $display("%0t: audible_count exp %0d got %0d", $time, e.audible_count,
                        rsp_data.audible_count);
            if (rsp_data.last !== e.last)
               $display("%0t: last exp %0d got %0d (step %0d)", $time, e.last,
                        rsp_data.last, e.step_index);
            if (e.last && e.status <= sgpv_pkg::STATUS_EMPTY) status_hits[e.status]++;
         end
      end
   end

   initial begin
      sgpv_pkg::req_type r;
      int                pick;
      int                waited;
      for (int i = 0; i < 5; i++) status_hits[i] = 0;
      //                  source    retrig    contin    release  at_start typed status
      directed_rows[0]  = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, S_EMPTY};
      directed_rows[1]  = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, S_EMPTY};
      directed_rows[2]  = {16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b1, S_OVERLAP};
      directed_rows[3]  = {16'h8000, 16'h0000, 16'h8000, 16'h0000, 1'b0, 1'b1, S_OVERLAP};
      directed_rows[4]  = {16'h0001, 16'h0000, 16'h0000, 16'h0001, 1'b0, 1'b1, S_OVERLAP};
      directed_rows[5]  = {16'h0000, 16'h0010, 16'h0010, 16'h0000, 1'b1, 1'b1, S_OVERLAP};
      directed_rows[6]  = {16'h0000, 16'h4000, 16'h0000, 16'h4000, 1'b1, 1'b1, S_OVERLAP};
      directed_rows[7]  = {16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, S_OVERLAP};
      directed_rows[8]  = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, S_OVERLAP};
      directed_rows[9]  = {16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b1, S_ORPHAN};
      directed_rows[10] = {16'h0010, 16'h0008, 16'h0000, 16'h0000, 1'b0, 1'b1, S_ORPHAN};
      directed_rows[11] = {16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b1, 1'b1, S_TOPO};
      directed_rows[12] = {16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b1, 1'b1, S_TOPO};
      directed_rows[13] = {16'h0001, 16'h0000, 16'h0000, 16'h0006, 1'b0, 1'b1, S_TOPO};
      directed_rows[14] = {16'h0001, 16'h0000, 16'h0004, 16'h0000, 1'b0, 1'b1, S_TOPO};
      directed_rows[15] = {16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, S_OK};
      directed_rows[16] = {16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0, S_OK};
      directed_rows[17] = {16'h0001, 16'h0000, 16'hFFFE, 16'h0000, 1'b0, 1'b0, S_OK};
      directed_rows[18] = {16'h0001, 16'h0000, 16'h7FFE, 16'h8000, 1'b0, 1'b0, S_OK};
      directed_rows[19] = {16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 1'b0, 1'b0, S_OK};
      directed_rows[20] = {16'h0102, 16'h0081, 16'h0000, 16'h0000, 1'b1, 1'b0, S_OK};
      directed_rows[21] = {16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, S_OK};
      directed_rows[22] = {16'h0000, 16'h0001, 16'hFFFE, 16'h0000, 1'b1, 1'b0, S_OK};
      directed_rows[23] = {16'h0F01, 16'h00F0, 16'h0000, 16'h0000, 1'b1, 1'b0, S_OK};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_bar(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].status);

      for (int n = 0; n < RANDOM_N; n++) begin
         gaps_enabled = !(n >= 40 && n < 70);
         pick = $urandom_range(99);
         if (pick < 75) begin
            r = make_bar();
         end else if (pick < 88) begin
            r = make_bar();
            case ($urandom_range(3))
               0: r.source_onsets[$urandom_range(15)]      = 1'b1;
               1: r.retrigger_onsets[$urandom_range(15)]   = 1'b1;
               2: r.continuation_steps[$urandom_range(15)] = 1'b1;
               default: r.release_steps[$urandom_range(15)] = 1'b1;
            endcase
         end else begin
            r.source_onsets      = 16'($urandom() & $urandom());
            r.retrigger_onsets   = 16'($urandom() & $urandom());
            r.continuation_steps = 16'($urandom());
            r.release_steps      = 16'($urandom() & $urandom());
            r.source_at_start    = 1'($urandom_range(1));
         end
         send_bar(r, 1'b0, sgpv_pkg::STATUS_OK);
      end
      start <= 1'b0;

      waited = 0;
      while (planned_steps.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (planned_steps.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d step responses never arrived", $time, planned_steps.size());
      end

      $display("Ran %0d bar requests, %0d step responses checked", bars_sent,
               responses_checked);
      $display("Bars by status: ok %0d, overlap %0d, orphan %0d, topology %0d, empty %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4]);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
